// ===== src/hufmt_pkg.sv =====
// Shared types, constants and helpers for the upper-case hex field formatter.
// Used by the front classifier, the descriptor queue and the character emitter.
package hufmt_pkg;

  // Counts of characters and positions within one field (up to 64).
  localparam int CNT_W = 7;

  // Default cap on the total field length.
  localparam int MAX_FIELD_DEF = 64;

  // Entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Length selector codes.
  localparam logic [1:0] LEN_8  = 2'd0;
  localparam logic [1:0] LEN_16 = 2'd1;
  localparam logic [1:0] LEN_32 = 2'd2;
  localparam logic [1:0] LEN_64 = 2'd3;

  // Number of hex digits in a 64-bit value.
  localparam int NIBBLES = 16;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h41;

  // One classified field, ready for the emitter.
  typedef struct packed {
    logic [63:0]      value;      // truncated value
    logic [CNT_W-1:0] pfx_start;  // position of the '0' of "0X"
    logic [CNT_W-1:0] dig_start;  // first digit position
    logic [CNT_W-1:0] dig_end;    // one past the last digit position
    logic [CNT_W-1:0] total;      // characters in the field, never zero here
    logic             has_pfx;
    logic             pad_zero;   // pad with '0' rather than ' '
  } desc_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'd0, nib};
    end else begin
      c = CHAR_A + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== src/hex_upper_field_formatter.sv =====
// Top level of the upper-case hex field formatter (printf %X style).
// Depends on hufmt_pkg, hufmt_front, hufmt_queue and hufmt_back.
//
// Each accepted input transaction yields its field as one output transaction
// per character, the final one flagged with tlast; the emitter's position
// counter issues one character a cycle unless the output stalls, and a field
// already queued follows its predecessor without a gap. Fields of zero length
// (value 0, precision 0, width 0) produce no output. The first character goes
// through the descriptor queue, the emitter's descriptor register and the
// output register. Input is taken while the two-entry descriptor queue has
// room, independent of output stalls; total length is capped at MAX_FIELD.
module hex_upper_field_formatter #(
  parameter int MAX_FIELD = hufmt_pkg::MAX_FIELD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // value[63:0], length_select[65:64], field_width[72:66], precision[79:73],
  // flag_minus[80], flag_zero[81], flag_hash[82], zero fill [87:83]
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_char[7:0]
  output logic [7:0]  m_tdata,
  output logic        m_tlast
);

  hufmt_pkg::desc_t front_desc;
  hufmt_pkg::desc_t q_head;
  logic             front_nonempty;
  logic             q_not_full;
  logic             q_not_empty;
  logic             q_push;
  logic             q_pop;

  hufmt_front #(
    .MAX_FIELD(MAX_FIELD)
  ) u_front (
    .value        (s_tdata[63:0]),
    .length_select(s_tdata[65:64]),
    .field_width  (s_tdata[72:66]),
    .precision    (s_tdata[79:73]),
    .flag_minus   (s_tdata[80]),
    .flag_zero    (s_tdata[81]),
    .flag_hash    (s_tdata[82]),
    .desc         (front_desc),
    .nonempty     (front_nonempty)
  );

  assign s_tready = q_not_full;
  // Drop empty fields here; they produce no characters.
  assign q_push   = s_tvalid && q_not_full && front_nonempty;

  hufmt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(front_desc),
    .not_full (q_not_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  hufmt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_not_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

// ===== src/hufmt_front.sv =====
// Front classifier: truncates the value, counts digits and lays out the field.
// Depends on hufmt_pkg for the descriptor type and length codes.
module hufmt_front #(
  parameter int MAX_FIELD = hufmt_pkg::MAX_FIELD_DEF
) (
  input  logic [63:0]     value,
  input  logic [1:0]      length_select,
  input  logic [6:0]      field_width,
  input  logic [6:0]      precision,
  input  logic            flag_minus,
  input  logic            flag_zero,
  input  logic            flag_hash,
  output hufmt_pkg::desc_t desc,
  output logic            nonempty
);

  localparam logic [7:0] MAX8 = 8'(MAX_FIELD);

  logic [63:0] n;
  logic [hufmt_pkg::NIBBLES-1:0] nz;
  logic [3:0]  msd;
  logic        any_nz;
  logic        has_prec;
  logic [7:0]  prec8;
  logic [7:0]  min_dig;
  logic [7:0]  dig_raw;
  logic [7:0]  dig_cap;
  logic [7:0]  digits;
  logic [7:0]  pfx_len;
  logic [7:0]  width;
  logic [7:0]  body;
  logic [7:0]  total;
  logic [7:0]  pad;
  logic        zero_pad;
  logic [7:0]  pfx_start;
  logic [7:0]  dig_start;
  logic [7:0]  dig_end;

  always_comb begin
    case (length_select)
      hufmt_pkg::LEN_8:  n = {56'd0, value[7:0]};
      hufmt_pkg::LEN_16: n = {48'd0, value[15:0]};
      hufmt_pkg::LEN_32: n = {32'd0, value[31:0]};
      default:           n = value;
    endcase
  end

  // Find the most significant nonzero digit.
  always_comb begin
    msd = 4'd0;
    for (int j = 0; j < hufmt_pkg::NIBBLES; j++) begin
      nz[j] = |n[4*j +: 4];
      if (nz[j]) begin
        msd = 4'(j);
      end
    end
    any_nz = |nz;
  end

  always_comb begin
    has_prec = !precision[6];
    prec8    = {1'b0, precision};
    if (any_nz) begin
      min_dig = {4'd0, msd} + 8'd1;
    end else if (has_prec && precision == 7'd0) begin
      min_dig = 8'd0;
    end else begin
      min_dig = 8'd1;
    end
    dig_raw  = (has_prec && prec8 > min_dig) ? prec8 : min_dig;
    pfx_len  = (any_nz && flag_hash) ? 8'd2 : 8'd0;
    dig_cap  = MAX8 - pfx_len;
    digits   = (dig_raw > dig_cap) ? dig_cap : dig_raw;
    width    = ({1'b0, field_width} > MAX8) ? MAX8 : {1'b0, field_width};
    body     = digits + pfx_len;
    total    = (width > body) ? width : body;
    pad      = total - body;
    zero_pad = flag_zero && !flag_minus && !has_prec;
    pfx_start = (flag_minus || zero_pad) ? 8'd0 : pad;
    dig_start = flag_minus ? pfx_len : pfx_len + pad;
    dig_end   = dig_start + digits;
  end

  always_comb begin
    desc.value     = n;
    desc.pfx_start = pfx_start[hufmt_pkg::CNT_W-1:0];
    desc.dig_start = dig_start[hufmt_pkg::CNT_W-1:0];
    desc.dig_end   = dig_end[hufmt_pkg::CNT_W-1:0];
    desc.total     = total[hufmt_pkg::CNT_W-1:0];
    desc.has_pfx   = pfx_len != 8'd0;
    desc.pad_zero  = zero_pad;
    nonempty       = total != 8'd0;
  end

endmodule

// ===== src/hufmt_queue.sv =====
// Short descriptor queue between the front classifier and the emitter.
// Depends on hufmt_pkg for the descriptor type and queue depth.
module hufmt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hufmt_pkg::desc_t push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output hufmt_pkg::desc_t head
);

  localparam int DEPTH = hufmt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  hufmt_pkg::desc_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign not_full  = count != CNT_QW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> not_full)
    else $error("queue pushed while full");

endmodule

// ===== src/hufmt_back.sv =====
// Character emitter: walks one descriptor a character per cycle, unless the
// output stalls, into an output register; hufmt_pkg gives its types and codes.
module hufmt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  hufmt_pkg::desc_t q_head,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);

  hufmt_pkg::desc_t cur;
  logic                       busy;
  logic [hufmt_pkg::CNT_W-1:0] pos;

  logic                        adv;
  logic                        at_last;
  logic                        in_pfx;
  logic                        in_dig;
  logic [hufmt_pkg::CNT_W-1:0] idx;
  logic [7:0]                  ch;

  assign adv     = !m_tvalid || m_tready;
  assign at_last = pos == cur.total - 1'b1;
  assign q_pop   = adv && q_valid && (!busy || at_last);

  always_comb begin
    in_pfx = cur.has_pfx && (pos == cur.pfx_start || pos == cur.pfx_start + 1'b1);
    in_dig = pos >= cur.dig_start && pos < cur.dig_end;
    idx    = cur.dig_end - 1'b1 - pos;
    if (in_pfx) begin
      ch = (pos == cur.pfx_start) ? hufmt_pkg::CHAR_ZERO : hufmt_pkg::CHAR_X;
    end else if (in_dig) begin
      if (idx >= hufmt_pkg::CNT_W'(hufmt_pkg::NIBBLES)) begin
        ch = hufmt_pkg::CHAR_ZERO;
      end else begin
        ch = hufmt_pkg::hex_char(cur.value[4*idx[3:0] +: 4]);
      end
    end else begin
      ch = cur.pad_zero ? hufmt_pkg::CHAR_ZERO : hufmt_pkg::CHAR_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (adv && busy) begin
      m_tdata <= ch;
      m_tlast <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= busy;
      if (q_pop) begin
        busy <= 1'b1;
        pos  <= '0;
      end else if (busy && at_last) begin
        busy <= 1'b0;
      end else if (busy) begin
        pos <= pos + 1'b1;
      end
    end
  end

  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    busy |-> cur.total != '0)
    else $error("empty field reached the emitter");
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pos < cur.total)
    else $error("emit position past field end");
  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    (busy && adv && at_last) |=> (m_tvalid && m_tlast))
    else $error("final character not marked last");

endmodule

// ===== dv/tb_hex_upper_field_formatter.sv =====
// Self-checking testbench for hex_upper_field_formatter (printf %X style text).
// Depends on hufmt_pkg and the formatter RTL; predicts each field's characters
// in a scoreboard class and compares every output transaction against them.
module tb_hex_upper_field_formatter;

  localparam int MAX_CHARS      = hufmt_pkg::MAX_FIELD_DEF;
  localparam int RANDOM_FIELDS  = 200;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 16;

  // Input transaction layout, highest field first.
  typedef struct packed {
    logic [4:0]  fill;
    logic        hash;
    logic        zero;
    logic        minus;
    logic [6:0]  prec;
    logic [6:0]  width;
    logic [1:0]  len;
    logic [63:0] value;
  } fmt_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  class hex_text_board;
    text_char_t pending_chars[$];
    int errors;
    int fields;
    int empty_fields;
    int chars_seen;
    int longest;

    function int pending();
      return pending_chars.size();
    endfunction

    task flag_mismatch(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Build the character sequence for one accepted field.
    function void queue_field_chars(input fmt_req_t r);
      logic [63:0] n;
      logic [63:0] t;
      logic [3:0]  nib;
      int digits, prefix, width, total, pad, prec, k, pos;
      bit has_prec, left, zpad;
      text_char_t c;
      case (r.len)
        hufmt_pkg::LEN_8:  n = r.value & 64'hFF;
        hufmt_pkg::LEN_16: n = r.value & 64'hFFFF;
        hufmt_pkg::LEN_32: n = r.value & 64'hFFFF_FFFF;
        default:           n = r.value;
      endcase
      prec = $signed(r.prec);
      has_prec = prec >= 0;
      digits = (has_prec && prec == 0 && n == 0) ? 0 : 1;
      for (t = n >> 4; t != 0; t = t >> 4) begin
        digits++;
      end
      if (has_prec && prec > digits) begin
        digits = prec;
      end
      prefix = (n != 0 && r.hash) ? 2 : 0;
      if (digits > MAX_CHARS - prefix) begin
        digits = MAX_CHARS - prefix;
      end
      width = (r.width > MAX_CHARS) ? MAX_CHARS : int'(r.width);
      total = digits + prefix;
      if (width > total) begin
        total = width;
      end
      pad = total - digits - prefix;
      left = r.minus;
      zpad = r.zero && !left && !has_prec;

      fields++;
      if (total == 0) begin
        empty_fields++;
      end
      if (total > longest) begin
        longest = total;
      end
      for (int i = 0; i < total; i++) begin
        k = i;
        c.last = (i + 1 == total);
        if (!left && !zpad && k < pad) begin
          c.ch = hufmt_pkg::CHAR_SPACE;
        end else begin
          if (!left && !zpad) begin
            k -= pad;
          end
          if (k < prefix) begin
            c.ch = (k == 0) ? hufmt_pkg::CHAR_ZERO : hufmt_pkg::CHAR_X;
          end else begin
            k -= prefix;
            if (zpad && k < pad) begin
              c.ch = hufmt_pkg::CHAR_ZERO;
            end else begin
              if (zpad) begin
                k -= pad;
              end
              if (k < digits) begin
                pos = digits - 1 - k;
                if (pos >= hufmt_pkg::NIBBLES) begin
                  c.ch = hufmt_pkg::CHAR_ZERO;
                end else begin
                  nib = n[4*pos +: 4];
                  c.ch = (nib < 4'd10) ? hufmt_pkg::CHAR_ZERO + 8'(nib)
                                       : hufmt_pkg::CHAR_A + 8'(nib) - 8'd10;
                end
              end else begin
                c.ch = hufmt_pkg::CHAR_SPACE;
              end
            end
          end
        end
        pending_chars.push_back(c);
      end
    endfunction

    task check_char(input logic [7:0] ch, input logic last);
      text_char_t want;
      chars_seen++;
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected char 0x%02h last=%b", ch, last));
      end else begin
        want = pending_chars.pop_front();
        if (ch !== want.ch) begin
          flag_mismatch($sformatf("char 0x%02h, wanted 0x%02h", ch, want.ch));
        end
        if (last !== want.last) begin
          flag_mismatch($sformatf("tlast %b, wanted %b (char 0x%02h)", last, want.last,
                                  want.ch));
        end
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  hex_text_board board;
  bit tx_steady;
  bit rx_steady;
  bit rx_hold_req;

  hex_upper_field_formatter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic fmt_req_t mk_req(input logic [63:0] value, input logic [1:0] len,
                                      input int width, input int prec,
                                      input bit minus, input bit zero, input bit hash);
    fmt_req_t r;
    r.fill  = '0;
    r.value = value;
    r.len   = len;
    r.width = width[6:0];
    r.prec  = prec[6:0];
    r.minus = minus;
    r.zero  = zero;
    r.hash  = hash;
    return r;
  endfunction

  // Mostly short fields; now and then the full 7-bit range of width and precision.
  function automatic fmt_req_t rand_req();
    logic [63:0] v;
    int width, prec;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = '1;
      default: v = {$urandom, $urandom} >> (4 * $urandom_range(15));
    endcase
    width = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(24);
    case ($urandom_range(9))
      0, 1, 2, 3: prec = -1;
      4:          prec = $urandom_range(127);
      default:    prec = $urandom_range(20);
    endcase
    return mk_req(v, 2'($urandom_range(3)), width, prec, 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  task automatic send_field(input fmt_req_t r);
    while (!tx_steady && $urandom_range(99) < 23) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Output side backpressure; a hold request stalls it for a long stretch.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        m_tready    <= 1'b0;
        rx_hold_req <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_tready <= rx_steady || ($urandom_range(99) >= 23);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        board.queue_field_chars(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        board.check_char(m_tdata, m_tlast);
      end
    end
  end

  // End the run if neither side moves a transaction for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("stalled for %0d cycles with %0d chars outstanding", STALL_LIMIT,
             board.pending());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    board       = new();
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    rx_hold_req = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed corners.
    send_field(mk_req(64'h0, hufmt_pkg::LEN_64, 0, -1, 0, 0, 0));
    send_field(mk_req(64'h0, hufmt_pkg::LEN_64, 0, 0, 0, 0, 0));  // empty field
    send_field(mk_req(64'h0, hufmt_pkg::LEN_64, 0, 0, 0, 0, 1));  // empty even with hash
    send_field(mk_req(64'h0, hufmt_pkg::LEN_32, 5, 0, 0, 0, 0));  // spaces only
    send_field(mk_req('1, hufmt_pkg::LEN_64, 0, -1, 0, 0, 1));
    send_field(mk_req('1, hufmt_pkg::LEN_8, 0, -1, 0, 0, 0));
    send_field(mk_req(64'h1234_5678_9ABC_DEF0, hufmt_pkg::LEN_16, 0, -1, 0, 0, 1));
    send_field(mk_req(64'hFEDC_BA98_7654_3210, hufmt_pkg::LEN_32, 12, -1, 0, 0, 1));
    // truncates to zero, no prefix
    send_field(mk_req(64'h100, hufmt_pkg::LEN_8, 4, -1, 0, 0, 1));
    send_field(mk_req('1, hufmt_pkg::LEN_64, 127, -1, 1, 0, 1));  // width saturates, left
    // width saturates, zero pad
    send_field(mk_req(64'hA5, hufmt_pkg::LEN_64, 127, -1, 0, 1, 1));
    send_field(mk_req(64'hBEEF, hufmt_pkg::LEN_64, 64, -1, 0, 1, 0));
    send_field(mk_req('1, hufmt_pkg::LEN_64, 0, 63, 0, 0, 1));    // precision saturates
    send_field(mk_req(64'h0, hufmt_pkg::LEN_64, 0, 62, 0, 0, 0));
    send_field(mk_req(64'h0123_4567_89AB_CDEF, hufmt_pkg::LEN_64, 0, 20, 0, 0, 0));
    // other negative precision
    send_field(mk_req(64'h3C, hufmt_pkg::LEN_64, 10, -2, 0, 1, 1));
    send_field(mk_req(64'h3C, hufmt_pkg::LEN_64, 10, -64, 0, 1, 0));
    send_field(mk_req(64'h3C, hufmt_pkg::LEN_64, 10, -1, 1, 1, 1)); // minus overrides zero
    // precision overrides zero
    send_field(mk_req(64'h3C, hufmt_pkg::LEN_64, 10, 4, 0, 1, 1));
    send_field(mk_req(64'hD00D, hufmt_pkg::LEN_64, 20, -1, 0, 0, 1));
    send_field(mk_req(64'hD00D, hufmt_pkg::LEN_64, 20, 6, 1, 0, 1));
    send_field(mk_req(64'h0, hufmt_pkg::LEN_64, 7, -1, 0, 0, 1));  // zero value ignores hash
    send_field(mk_req(64'h0, hufmt_pkg::LEN_64, 7, -1, 0, 1, 0));

    for (int i = 0; i < RANDOM_FIELDS; i++) begin
      if (i == 50) begin
        rx_hold_req <= 1'b1;
      end
      if (i == 110) begin
        wait_drained();
      end
      tx_steady = (i >= 140 && i < 180);
      rx_steady = tx_steady;
      send_field(rand_req());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_drained();

    $display("fields %0d (%0d empty), chars checked %0d, longest field %0d", board.fields,
             board.empty_fields, board.chars_seen, board.longest);
    $display("covered output hold-off with input backpressure and a full drain pause");
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
